// ----- rtl/core/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console writer package
// Shared constants, field types and transaction structures for the console.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;

    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int ADDR_W = $clog2(CELLS);

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [ATTR_W-1:0] attr_t;
    typedef logic [CELL_W-1:0] cell_t;
    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [ROW_W:0]    row_sum_t;
    typedef logic [COL_W-1:0]  col_t;
    typedef logic [ADDR_W-1:0] addr_t;

    localparam logic ACT_PUT  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    localparam char_t CH_NEWLINE   = 8'h0A;
    localparam char_t CH_BACKSPACE = 8'h08;
    localparam char_t CH_SPACE     = 8'h20;
    localparam attr_t RESET_ATTR   = 8'h07;
    localparam cell_t RESET_CELL   = {RESET_ATTR, CH_SPACE};

    typedef struct packed {
        logic  action;
        char_t char_code;
        row_t  read_row;
        col_t  read_col;
    } cmd_t;

    typedef struct packed {
        char_t cell_char;
        attr_t cell_attr;
        row_t  cursor_row;
        col_t  cursor_col;
    } rsp_t;

    typedef struct packed {
        logic  we;
        addr_t addr;
        cell_t data;
    } ram_wr_t;

    // Linear address of a cell from its physical row and its column.
    function automatic addr_t cell_addr(row_t prow, col_t col);
        return addr_t'(prow) * addr_t'(COLUMNS) + addr_t'(col);
    endfunction

endpackage

// ----- rtl/core/tcw_if.sv -----
// ----------------------------------------------------------------------------
// Text console writer channels
// Valid/ready interfaces for the command and response channels.
// ----------------------------------------------------------------------------
interface tcw_cmd_if;
    logic          valid;
    logic          ready;
    logic          action;
    tcw_pkg::char_t char_code;
    tcw_pkg::row_t  read_row;
    tcw_pkg::col_t  read_col;

    modport source (output valid, output action, output char_code, output read_row,
                    output read_col, input ready);
    modport sink   (input valid, input action, input char_code, input read_row,
                    input read_col, output ready);
endinterface

interface tcw_rsp_if;
    logic           valid;
    logic           ready;
    tcw_pkg::char_t cell_char;
    tcw_pkg::attr_t cell_attr;
    tcw_pkg::row_t  cursor_row;
    tcw_pkg::col_t  cursor_col;

    modport source (output valid, output cell_char, output cell_attr, output cursor_row,
                    output cursor_col, input ready);
    modport sink   (input valid, input cell_char, input cell_attr, input cursor_row,
                    input cursor_col, output ready);
endinterface

// ----- rtl/core/tcw_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// Text console sequencer
// Cursor, scroll offset and sweep control around the screen memory.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  tcw_pkg::attr_t   cfg_wr_data,
    input  logic             cmd_valid,
    input  tcw_pkg::cmd_t    cmd,
    output logic             cmd_ready,
    output logic             res_valid,
    output tcw_pkg::rsp_t    res,
    input  logic             res_ready,
    output tcw_pkg::ram_wr_t ram_wr,
    output tcw_pkg::addr_t   ram_raddr,
    input  tcw_pkg::cell_t   ram_rdata
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SCROLL,
        S_DONE
    } state_t;

    state_t         state_reg, state_next;
    tcw_pkg::row_t  row_reg, row_next;
    tcw_pkg::col_t  col_reg, col_next;
    tcw_pkg::row_t  prow_reg, prow_next;
    tcw_pkg::row_t  top_reg, top_next;
    tcw_pkg::addr_t sweep_addr_reg, sweep_addr_next;
    tcw_pkg::addr_t sweep_end_reg, sweep_end_next;
    tcw_pkg::attr_t color_reg, color_next;
    tcw_pkg::rsp_t  res_reg, res_next;

    tcw_pkg::row_sum_t read_sum;
    tcw_pkg::row_t     read_prow;
    logic              read_in_grid;
    logic              line_feed;
    tcw_pkg::col_t     wr_col;

    // The screen is a ring of rows: top_reg is the physical row shown first.
    assign read_sum  = tcw_pkg::row_sum_t'(cmd.read_row) + tcw_pkg::row_sum_t'(top_reg);
    assign read_prow = (32'(read_sum) >= tcw_pkg::ROWS)
                       ? tcw_pkg::row_t'(32'(read_sum) - tcw_pkg::ROWS)
                       : tcw_pkg::row_t'(read_sum);
    assign read_in_grid = (32'(cmd.read_row) < tcw_pkg::ROWS) &&
                          (32'(cmd.read_col) < tcw_pkg::COLUMNS);
    assign ram_raddr = tcw_pkg::cell_addr(read_prow, cmd.read_col);

    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_comb
    begin
        state_next      = state_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        prow_next       = prow_reg;
        top_next        = top_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_end_next  = sweep_end_reg;
        color_next      = cfg_wr_en ? cfg_wr_data : color_reg;
        res_next        = res_reg;
        ram_wr          = '0;
        line_feed       = 1'b0;
        wr_col          = col_reg;

        case (state_reg)
            S_CLEAR, S_SCROLL:
            begin
                ram_wr.we   = 1'b1;
                ram_wr.addr = sweep_addr_reg;
                ram_wr.data = (state_reg == S_CLEAR) ? tcw_pkg::RESET_CELL
                                                     : {color_reg, tcw_pkg::CH_SPACE};
                if (sweep_addr_reg == sweep_end_reg)
                begin
                    state_next = (state_reg == S_CLEAR) ? S_IDLE : S_DONE;
                end
                else
                begin
                    sweep_addr_next = sweep_addr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.action == tcw_pkg::ACT_READ)
                    begin
                        res_next = '{cell_char: '0, cell_attr: '0,
                                     cursor_row: row_reg, cursor_col: col_reg};
                        state_next = read_in_grid ? S_READ : S_DONE;
                    end
                    else
                    begin
                        if (cmd.char_code == tcw_pkg::CH_NEWLINE)
                        begin
                            line_feed = 1'b1;
                        end
                        else if (cmd.char_code == tcw_pkg::CH_BACKSPACE && col_reg != '0)
                        begin
                            wr_col      = col_reg - 1'b1;
                            col_next    = wr_col;
                            ram_wr.we   = 1'b1;
                            ram_wr.data = {color_reg, tcw_pkg::CH_SPACE};
                        end
                        else
                        begin
                            ram_wr.we   = 1'b1;
                            ram_wr.data = {color_reg, cmd.char_code};
                            if (32'(col_reg) == tcw_pkg::COLUMNS - 1)
                            begin
                                line_feed = 1'b1;
                            end
                            else
                            begin
                                col_next = col_reg + 1'b1;
                            end
                        end
                        ram_wr.addr = tcw_pkg::cell_addr(prow_reg, wr_col);

                        state_next = S_DONE;
                        if (line_feed)
                        begin
                            col_next = '0;
                            if (32'(row_reg) == tcw_pkg::ROWS - 1)
                            begin
                                // The old top row becomes the new bottom row and is blanked.
                                top_next = (32'(top_reg) == tcw_pkg::ROWS - 1)
                                           ? '0 : top_reg + 1'b1;
                                prow_next       = top_reg;
                                sweep_addr_next = tcw_pkg::cell_addr(top_reg, '0);
                                sweep_end_next  = tcw_pkg::cell_addr(top_reg,
                                                  tcw_pkg::col_t'(tcw_pkg::COLUMNS - 1));
                                state_next      = S_SCROLL;
                            end
                            else
                            begin
                                row_next  = row_reg + 1'b1;
                                prow_next = (32'(prow_reg) == tcw_pkg::ROWS - 1)
                                            ? '0 : prow_reg + 1'b1;
                            end
                        end
                        res_next = '{cell_char: '0, cell_attr: '0,
                                     cursor_row: row_next, cursor_col: col_next};
                    end
                end
            end

            S_READ:
            begin
                res_next.cell_char = ram_rdata[tcw_pkg::CHAR_W-1:0];
                res_next.cell_attr = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
                state_next         = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            row_reg        <= '0;
            col_reg        <= '0;
            prow_reg       <= '0;
            top_reg        <= '0;
            sweep_addr_reg <= '0;
            sweep_end_reg  <= tcw_pkg::addr_t'(tcw_pkg::CELLS - 1);
            color_reg      <= tcw_pkg::RESET_ATTR;
            res_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            row_reg        <= row_next;
            col_reg        <= col_next;
            prow_reg       <= prow_next;
            top_reg        <= top_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_end_reg  <= sweep_end_next;
            color_reg      <= color_next;
            res_reg        <= res_next;
        end
    end

endmodule

// ----- rtl/core/text_console_writer_core.sv -----
// ----------------------------------------------------------------------------
// Text console writer core
// Character grid with cursor, line wrap, backspace, newline and scrolling.
// ----------------------------------------------------------------------------
// After reset the block sweeps the whole screen memory to grey spaces, one
// cell a cycle, and accepts no command until that is done; the colour
// register may be written meanwhile. A read transaction passes through the
// idle, read and done states (idle and done when it falls outside the
// grid) and an ordinary put through idle and done, as the screen memory has
// a single write port and a registered read port. A put that moves past the
// last row scrolls by advancing a row offset and then blanks the new bottom
// row through the same port, one cell a cycle.
// The response sits in an output register, so a new command is taken while
// the previous response waits.
module text_console_writer_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  tcw_pkg::attr_t cfg_wr_data,
    tcw_cmd_if.sink        cmd,
    tcw_rsp_if.source      rsp
);

    tcw_pkg::cmd_t    cmd_item;
    tcw_pkg::rsp_t    res;
    logic             res_valid;
    logic             res_ready;
    tcw_pkg::ram_wr_t ram_wr;
    tcw_pkg::addr_t   ram_raddr;
    tcw_pkg::cell_t   ram_rdata;

    logic          out_valid_reg;
    tcw_pkg::rsp_t out_data_reg;

    assign cmd_item = '{action: cmd.action, char_code: cmd.char_code,
                        read_row: cmd.read_row, read_col: cmd.read_col};

    tcw_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd.valid),
        .cmd         (cmd_item),
        .cmd_ready   (cmd.ready),
        .res_valid   (res_valid),
        .res         (res),
        .res_ready   (res_ready),
        .ram_wr      (ram_wr),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata)
    );

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (tcw_pkg::CELLS)
    ) u_screen_ram (
        .clk   (clk),
        .we    (ram_wr.we),
        .waddr (ram_wr.addr),
        .wdata (ram_wr.data),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: loads when empty or when its transaction completes.
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_data_reg <= res;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.cell_char  = out_data_reg.cell_char;
    assign rsp.cell_attr  = out_data_reg.cell_attr;
    assign rsp.cursor_row = out_data_reg.cursor_row;
    assign rsp.cursor_col = out_data_reg.cursor_col;

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put and read commands into the console core through the command
// channel and checks every response against a shadow copy of the screen,
// the cursor and the text colour kept inside the testbench. The colour
// register is exercised at its reset value and at several written values.
// ----------------------------------------------------------------------------
module testbench;
    import tcw_pkg::*;

    logic  clk;
    logic  rst_n;
    logic  cfg_wr_en;
    attr_t cfg_wr_data;

    tcw_cmd_if cmd_ch ();
    tcw_rsp_if rsp_ch ();

    text_console_writer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd_ch),
        .rsp         (rsp_ch)
    );

    // Shadow of the console state.
    cell_t shadow_cells [CELLS];
    int    cursor_r;
    int    cursor_c;
    attr_t text_colour;

    cmd_t  pending_cmds [$];
    rsp_t  awaited_rsps [$];
    cmd_t  cmd_on_bus;
    rsp_t  oldest_rsp;
    int    send_gap_pct;
    int    recv_gap_pct;
    int    mismatch_count;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("testbench: FAIL");
        $finish;
    end

    // Newline, or a wrap past the last column: scrolls the grid at the bottom.
    function automatic void start_next_line();
        int i;
        cursor_c = 0;
        cursor_r++;
        if (cursor_r >= ROWS)
        begin
            for (i = 0; i < (ROWS - 1) * COLUMNS; i++)
                shadow_cells[i] = shadow_cells[i + COLUMNS];
            for (i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
                shadow_cells[i] = {text_colour, CH_SPACE};
            cursor_r = ROWS - 1;
        end
    endfunction

    function automatic rsp_t console_step(input cmd_t c);
        rsp_t r;
        cell_t cell_word;
        r = '0;
        if (c.action == ACT_PUT)
        begin
            if (c.char_code == CH_NEWLINE)
                start_next_line();
            else if (c.char_code == CH_BACKSPACE && cursor_c > 0)
            begin
                cursor_c--;
                shadow_cells[cursor_r * COLUMNS + cursor_c] = {text_colour, CH_SPACE};
            end
            else
            begin
                // Backspace at column zero lands here and is stored as a byte.
                shadow_cells[cursor_r * COLUMNS + cursor_c] = {text_colour, c.char_code};
                cursor_c++;
                if (cursor_c >= COLUMNS)
                    start_next_line();
            end
        end
        else if (c.read_row < ROWS && c.read_col < COLUMNS)
        begin
            cell_word = shadow_cells[int'(c.read_row) * COLUMNS + int'(c.read_col)];
            r.cell_char = cell_word[CHAR_W-1:0];
            r.cell_attr = cell_word[CELL_W-1:CHAR_W];
        end
        r.cursor_row = row_t'(cursor_r);
        r.cursor_col = col_t'(cursor_c);
        return r;
    endfunction

    function automatic cmd_t make_cmd(logic act, char_t code, row_t row, col_t col);
        cmd_t c;
        c.action    = act;
        c.char_code = code;
        c.read_row  = row;
        c.read_col  = col;
        return c;
    endfunction

    // Mostly printable text with newlines, backspaces and reads near the grid;
    // a share of full-range bytes and out-of-grid reads.
    function automatic cmd_t random_cmd();
        int    pick;
        char_t code;
        row_t  row;
        col_t  col;
        pick = $urandom_range(99);
        code = char_t'($urandom_range(255));
        row  = ($urandom_range(9) == 0) ? row_t'($urandom_range(31))
                                        : row_t'($urandom_range(ROWS - 1));
        col  = ($urandom_range(9) == 0) ? col_t'($urandom_range(127))
                                        : col_t'($urandom_range(COLUMNS - 1));
        if (pick < 25)
            return make_cmd(ACT_READ, code, row, col);
        if (pick < 38)
            return make_cmd(ACT_PUT, CH_NEWLINE, row_t'($urandom_range(31)),
                            col_t'($urandom_range(127)));
        if (pick < 46)
            return make_cmd(ACT_PUT, CH_BACKSPACE, row_t'($urandom_range(31)),
                            col_t'($urandom_range(127)));
        if (pick < 82)
            code = char_t'($urandom_range(32, 126));
        return make_cmd(ACT_PUT, code, row_t'($urandom_range(31)),
                        col_t'($urandom_range(127)));
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic wait_until_drained();
        @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_ch.valid || awaited_rsps.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_text_colour(attr_t value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        text_colour = value;
        @(negedge clk);
    endtask

    task automatic queue_random(int count);
        repeat (count) pending_cmds.push_back(random_cmd());
    endtask

    // Command driver: predicts at the edge that completes a transaction.
    always @(posedge clk)
    begin
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
            awaited_rsps.push_back(console_step(cmd_on_bus));
        if (!rst_n)
            cmd_ch.valid <= 1'b0;
        else if (!cmd_ch.valid || cmd_ch.ready)
        begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_gap_pct)
            begin
                cmd_on_bus = pending_cmds.pop_front();
                cmd_ch.valid     <= 1'b1;
                cmd_ch.action    <= cmd_on_bus.action;
                cmd_ch.char_code <= cmd_on_bus.char_code;
                cmd_ch.read_row  <= cmd_on_bus.read_row;
                cmd_ch.read_col  <= cmd_on_bus.read_col;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // Response monitor.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (awaited_rsps.size() == 0)
            begin
                $display("%0t unexpected response: expected none, actual %h", $time,
                         {rsp_ch.cell_char, rsp_ch.cell_attr, rsp_ch.cursor_row,
                          rsp_ch.cursor_col});
                mismatch_count++;
            end
            else
            begin
                oldest_rsp = awaited_rsps.pop_front();
                check_field("cell_char", oldest_rsp.cell_char, rsp_ch.cell_char);
                check_field("cell_attr", oldest_rsp.cell_attr, rsp_ch.cell_attr);
                check_field("cursor_row", oldest_rsp.cursor_row, rsp_ch.cursor_row);
                check_field("cursor_col", oldest_rsp.cursor_col, rsp_ch.cursor_col);
            end
        end
        rsp_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
    end

    initial
    begin
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        cmd_ch.valid     = 1'b0;
        cmd_ch.action    = ACT_PUT;
        cmd_ch.char_code = '0;
        cmd_ch.read_row  = '0;
        cmd_ch.read_col  = '0;
        rsp_ch.ready     = 1'b0;
        send_gap_pct     = 19;
        recv_gap_pct     = 63;
        mismatch_count   = 0;
        cursor_r         = 0;
        cursor_c         = 0;
        text_colour      = RESET_ATTR;
        foreach (shadow_cells[i])
            shadow_cells[i] = RESET_CELL;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, with the colour register still at its reset value.
        pending_cmds.push_back(make_cmd(ACT_READ, 8'h00, 5'd0, 7'd0));
        pending_cmds.push_back(make_cmd(ACT_READ, 8'hFF, 5'd24, 7'd79));
        pending_cmds.push_back(make_cmd(ACT_READ, 8'h00, 5'd25, 7'd0));
        pending_cmds.push_back(make_cmd(ACT_READ, 8'h00, 5'd0, 7'd80));
        pending_cmds.push_back(make_cmd(ACT_READ, 8'hFF, 5'd31, 7'd127));
        pending_cmds.push_back(make_cmd(ACT_PUT, CH_BACKSPACE, 5'd0, 7'd0));
        pending_cmds.push_back(make_cmd(ACT_PUT, 8'h00, 5'd31, 7'd127));
        pending_cmds.push_back(make_cmd(ACT_PUT, 8'hFF, 5'd0, 7'd0));
        pending_cmds.push_back(make_cmd(ACT_PUT, 8'h80, 5'd31, 7'd127));
        pending_cmds.push_back(make_cmd(ACT_PUT, 8'h7F, 5'd0, 7'd0));
        pending_cmds.push_back(make_cmd(ACT_PUT, 8'h41, 5'd0, 7'd0));
        pending_cmds.push_back(make_cmd(ACT_PUT, CH_BACKSPACE, 5'd0, 7'd0));
        pending_cmds.push_back(make_cmd(ACT_PUT, CH_BACKSPACE, 5'd0, 7'd0));
        pending_cmds.push_back(make_cmd(ACT_READ, 8'h00, 5'd0, 7'd0));
        pending_cmds.push_back(make_cmd(ACT_READ, 8'h00, 5'd0, 7'd2));
        pending_cmds.push_back(make_cmd(ACT_READ, 8'h00, 5'd0, 7'd4));
        pending_cmds.push_back(make_cmd(ACT_PUT, CH_NEWLINE, 5'd0, 7'd0));
        pending_cmds.push_back(make_cmd(ACT_PUT, CH_NEWLINE, 5'd0, 7'd0));
        pending_cmds.push_back(make_cmd(ACT_PUT, 8'h5A, 5'd0, 7'd0));
        pending_cmds.push_back(make_cmd(ACT_READ, 8'h00, 5'd2, 7'd0));
        pending_cmds.push_back(make_cmd(ACT_READ, 8'h00, 5'd1, 7'd0));
        wait_until_drained();

        // The sender holds off between phases until every response is in.
        write_text_colour(8'hFF);
        queue_random(180);
        wait_until_drained();

        send_gap_pct = 63;
        recv_gap_pct = 19;
        write_text_colour(8'h00);
        queue_random(180);
        wait_until_drained();

        send_gap_pct = 0;
        recv_gap_pct = 0;
        write_text_colour(attr_t'($urandom_range(255)));
        queue_random(190);
        wait_until_drained();

        repeat (120) @(posedge clk);
        if (mismatch_count == 0 && awaited_rsps.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
